FILE: design/assert_macros.svh
// assertion macros used by the checker file ldc_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge, off while reset is high
`define CHK_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequence checked in the cycle after the antecedent
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/ldc_pkg.sv
// types, constants and light band lookup for the lamp dimmer controller
`default_nettype none

package ldc_pkg;

  localparam int IN_W   = 16;
  localparam int OUT_W  = 8;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // register indexes
  localparam logic REG_IDLE_TIMEOUT = 1'b0;

  localparam logic [15:0] TIMEOUT_RESET = 16'd60000;

  // light thresholds outside the banded range
  localparam logic [7:0] DARK_LIMIT   = 8'd59;
  localparam logic [7:0] BRIGHT_LIMIT = 8'd241;
  localparam logic [3:0] DARK_LEVEL   = 4'd9;
  localparam logic [3:0] BRIGHT_LEVEL = 4'd0;
  localparam int         NUM_BANDS    = 8;

  localparam logic [7:0] BAND_LO [NUM_BANDS] =
    '{8'd66, 8'd88, 8'd110, 8'd132, 8'd154, 8'd176, 8'd198, 8'd220};
  localparam logic [7:0] BAND_HI [NUM_BANDS] =
    '{8'd80, 8'd102, 8'd124, 8'd146, 8'd168, 8'd190, 8'd212, 8'd234};

  typedef struct packed {
    logic       hit;
    logic [3:0] target;
  } band_t;

  // map a light sample to a level; samples in a gap give no hit
  function automatic band_t band_lookup(input logic [7:0] sample);
    band_t res;
    res.hit    = 1'b0;
    res.target = 4'd0;
    if (sample < DARK_LIMIT) begin
      res.hit    = 1'b1;
      res.target = DARK_LEVEL;
    end else if (sample > BRIGHT_LIMIT) begin
      res.hit    = 1'b1;
      res.target = BRIGHT_LEVEL;
    end else begin
      for (int k = 0; k < NUM_BANDS; k++) begin
        if (sample >= BAND_LO[k] && sample <= BAND_HI[k]) begin
          res.hit    = 1'b1;
          res.target = 4'(NUM_BANDS - k);
        end
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: design/lamp_dimmer_controller.sv
// lamp dimmer controller top level: tick processing, output register, config port
//
// channel   dir  handshake                  payload
// s_*       in   s_tvalid / s_tready        one tick of key, light and presence inputs
// m_*       out  m_tvalid / m_tready        lamp drive, level and mode for that tick
// apb       in   psel & penable & pwrite    idle_timeout_ticks at byte address 0
//
// one tick is taken per clock cycle while s_tready is high; its result is in m_tdata on the next cycle
// the output register frees itself in the cycle it is taken, so s_tready stays
// high while results keep flowing
// rst (synchronous) restores level 0, auto mode, idle count 0, phase 0, lamp off
// and a timeout of 60000 ticks
// a stalled m_tready holds the result and drops s_tready until it is taken
`default_nettype none

module lamp_dimmer_controller
  import ldc_pkg::*;
#(
  parameter int LEVELS = 10
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // s_tdata: mode_toggle[0], step_down[1], step_up[2], light_valid[3],
  //          light_level[11:4], presence[12], zero[15:13]
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [IN_W-1:0]     s_tdata,
  // m_tdata: lamp_on[0], level[4:1], auto_mode[5], zero[7:6]
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [OUT_W-1:0]         m_tdata,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CFG_AW-1:0]   paddr,
  input  wire logic [CFG_DW-1:0]   pwdata,
  output logic [CFG_DW-1:0]        prdata,
  output logic                     pready
);

  localparam int         PHASE_W = (LEVELS > 2) ? $clog2(LEVELS) : 1;
  localparam logic [3:0] TOP     = 4'(LEVELS - 1);

  // state
  logic [15:0]        idle_timeout;
  logic [3:0]         bright_level;
  logic               mode_auto;
  logic [15:0]        idle_count;
  logic [PHASE_W-1:0] pwm_phase;
  logic               lamp_state;

  logic [3:0]         bright_level_next;
  logic               mode_auto_next;
  logic [15:0]        idle_count_next;
  logic [PHASE_W-1:0] pwm_phase_next;
  logic               lamp_state_next;

  // unpacked input fields
  logic       mode_toggle, step_down, step_up, light_valid, presence;
  logic [7:0] light_level;

  logic       in_xfer;
  band_t      band;
  logic [3:0] lvl_a;
  logic [16:0] idle_inc;
  logic [PHASE_W:0] phase_inc;
  logic       wrap;

  assign mode_toggle = s_tdata[0];
  assign step_down   = s_tdata[1];
  assign step_up     = s_tdata[2];
  assign light_valid = s_tdata[3];
  assign light_level = s_tdata[11:4];
  assign presence    = s_tdata[12];

  // output register handshake
  assign s_tready = !m_tvalid || m_tready;
  assign in_xfer  = s_tvalid && s_tready;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_IDLE_TIMEOUT) ? {16'd0, idle_timeout} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_IDLE_TIMEOUT) begin
      idle_timeout <= pwdata[15:0];
    end
  end

  assign band = band_lookup(light_level);

  // next state for one tick
  always_comb begin
    mode_auto_next = mode_auto ^ mode_toggle;

    // level from keys or light sample
    lvl_a = bright_level;
    if (!mode_auto_next) begin
      if (step_down && lvl_a != 4'd0) lvl_a = lvl_a - 4'd1;
      if (step_up && lvl_a < TOP) lvl_a = lvl_a + 4'd1;
    end else if (light_valid && idle_count < idle_timeout && band.hit) begin
      lvl_a = (band.target > TOP) ? TOP : band.target;
    end

    // saturating idle counter
    idle_inc = {1'b0, idle_count} + 17'd1;
    if (presence) begin
      idle_count_next = 16'd0;
    end else if (idle_inc > {1'b0, idle_timeout}) begin
      idle_count_next = idle_timeout;
    end else begin
      idle_count_next = idle_inc[15:0];
    end
    bright_level_next = (idle_count_next == idle_timeout) ? 4'd0 : lvl_a;

    // pwm phase and lamp drive
    phase_inc = {1'b0, pwm_phase} + (PHASE_W+1)'(1);
    wrap      = phase_inc >= (PHASE_W+1)'(LEVELS);
    pwm_phase_next = wrap ? '0 : phase_inc[PHASE_W-1:0];
    lamp_state_next = lamp_state;
    if (wrap && bright_level_next != 4'd0) lamp_state_next = 1'b1;
    if (4'(pwm_phase_next) == bright_level_next && bright_level_next != TOP) begin
      lamp_state_next = 1'b0;
    end
  end

  // state update on an input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      bright_level <= 4'd0;
      mode_auto    <= 1'b1;
      idle_count   <= 16'd0;
      pwm_phase    <= '0;
      lamp_state   <= 1'b0;
    end else if (in_xfer) begin
      bright_level <= bright_level_next;
      mode_auto    <= mode_auto_next;
      idle_count   <= idle_count_next;
      pwm_phase    <= pwm_phase_next;
      lamp_state   <= lamp_state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_xfer) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      m_tdata <= {2'b00, mode_auto_next, bright_level_next, lamp_state_next};
    end
  end

endmodule

`default_nettype wire

FILE: design/ldc_checker.sv
// port checker for the lamp dimmer controller and its bind
`default_nettype none
`include "assert_macros.svh"

module ldc_checker #(
  parameter int LEVELS = 10
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [15:0] s_tdata,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [7:0]  m_tdata
);

  logic in_xfer;
  logic out_xfer;

  assign in_xfer  = s_tvalid && s_tready;
  assign out_xfer = m_tvalid && m_tready;

  // a stalled result holds
  `CHK_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
  // every accepted tick yields a result next cycle
  `CHK_NEXT(a_in_result, clk, rst, in_xfer, m_tvalid, "accepted tick gave no result")
  // a taken result with no new tick leaves the output empty
  `CHK_NEXT(a_no_extra, clk, rst, out_xfer && !in_xfer, !m_tvalid, "result repeated")
  // empty output register always accepts
  `CHK_IMPLY(a_ready_empty, clk, rst, !m_tvalid, s_tready, "input blocked with empty output")
  // reported level stays in range
  `CHK_IMPLY(a_level_range, clk, rst, m_tvalid, m_tdata[4:1] <= 4'(LEVELS - 1), "level out of range")

endmodule

bind lamp_dimmer_controller ldc_checker #(.LEVELS(LEVELS)) u_ldc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
